/* hdl/cahc_pkg.sv */
// Shared widths, types and saturation helper for the cascaded altitude hold controller.
package cahc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int GAIN_W     = 16;
	localparam int PROD_W     = DATA_WIDTH + GAIN_W + 1;
	localparam int WIDE_W     = PROD_W + 1;
	localparam int MODE_W     = 3;
	localparam int THR_W      = 10;
	localparam int VEL_W      = 24;
	localparam int DT_W       = 16;
	localparam int IDX_W      = 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [WIDE_W-1:0]     wide_t;

	function automatic data_t sat_wide(input wide_t x);
		data_t r;
		if ((&x[WIDE_W-1:DATA_WIDTH-1]) || !(|x[WIDE_W-1:DATA_WIDTH-1])) begin
			r = x[DATA_WIDTH-1:0];
		end else if (x[WIDE_W-1]) begin
			r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* hdl/cascaded_altitude_hold_controller_top.sv */
// Top level of the cascaded altitude hold controller: sequencer, state and ports.
//
// One input word per control tick carries the mode switch, throttle, altitude, climb
// rate and time step; one output word returns target altitude, climb command and
// velocity drive. Both channels use valid/ready. Gains are written through a plain
// write port (cfg_we, cfg_index, cfg_data); the user must write them only while the
// block is idle, as the block itself does not enforce this.
// A single registered multiplier is shared by all five products under a small
// sequencer, and the block takes one word at a time. A hold-mode word runs through
// every multiplier step, while a manual word and any other mode use the multiplier
// only for the velocity drive. in_ready is high whenever the sequencer is idle,
// even while a finished result still waits in the output register. If the receiver
// stalls, the next word is processed up to its last step and waits there until the
// output register is free.
//
// Reset clears the target, integrator, held command and previous mode to zero, sets
// the position and velocity gains to 1.0 and the integral gain to 0.
module cascaded_altitude_hold_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cahc_pkg::MODE_W-1:0]   mode_switch,
	input  logic [cahc_pkg::THR_W-1:0]    throttle,
	input  logic signed [31:0]            altitude,
	input  logic signed [cahc_pkg::VEL_W-1:0] vertical_velocity,
	input  logic [cahc_pkg::DT_W-1:0]     time_step,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            target_altitude,
	output logic signed [31:0]            climb_command,
	output logic signed [31:0]            velocity_drive,
	input  logic                          cfg_we,
	input  logic [cahc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [cahc_pkg::GAIN_W-1:0]   cfg_data
);
	import cahc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ADJ  = 4'd1;
	localparam logic [3:0] ST_TGT  = 4'd2;
	localparam logic [3:0] ST_ERR  = 4'd3;
	localparam logic [3:0] ST_MI   = 4'd4;
	localparam logic [3:0] ST_PI   = 4'd5;
	localparam logic [3:0] ST_MDT  = 4'd6;
	localparam logic [3:0] ST_INT  = 4'd7;
	localparam logic [3:0] ST_CLP  = 4'd8;
	localparam logic [3:0] ST_PP   = 4'd9;
	localparam logic [3:0] ST_CMD  = 4'd10;
	localparam logic [3:0] ST_MAN  = 4'd11;
	localparam logic [3:0] ST_VERR = 4'd12;
	localparam logic [3:0] ST_VMUL = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	localparam logic [MODE_W-1:0] MODE_MANUAL     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL_ALT = 3'd3;

	localparam logic [IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_VELOCITY_GAIN = 2'd2;

	localparam int LIM_W  = 15;
	localparam int VERR_W = 17;
	localparam int EX_W   = THR_W + 1;
	localparam int MAN_W  = EX_W + 7;

	localparam logic [THR_W-1:0]          THR_HIGH    = 10'd600;
	localparam logic [THR_W-1:0]          THR_LOW     = 10'd400;
	localparam logic signed [EX_W-1:0]    THR_MID     = 11'sd450;
	localparam logic signed [MAN_W-1:0]   MAN_LIMIT   = 18'sd64000;
	localparam logic [DATA_WIDTH:0]       INT_LIM_MIN = 33'd5120;
	localparam logic [DATA_WIDTH:0]       INT_LIM_MAX = 33'd12800;
	localparam logic signed [DATA_WIDTH:0] VERR_LIMIT = 33'sd38400;
	localparam logic signed [VERR_W-1:0]  VERR_MAX    = 17'sd38400;

	logic [3:0]               state_q;
	logic [MODE_W-1:0]        prev_mode_q;
	logic [GAIN_W-1:0]        pos_gain_q;
	logic [GAIN_W-1:0]        int_gain_q;
	logic [GAIN_W-1:0]        vel_gain_q;
	data_t                    tgt_q;
	data_t                    integ_q;
	data_t                    cmd_q;
	data_t                    err_q;
	data_t                    p_q;
	logic [LIM_W-1:0]         lim_q;
	logic signed [VERR_W-1:0] verr_q;
	logic [THR_W-1:0]         thr_q;
	data_t                    alt_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic [DT_W-1:0]          dt_q;
	logic                     out_valid_q;
	data_t                    out_tgt_q;
	data_t                    out_cmd_q;
	data_t                    out_drive_q;

	logic                     mul_en;
	data_t                    mul_a;
	logic [GAIN_W-1:0]        mul_b;
	prod_t                    prod_q;

	logic signed [EX_W-1:0]   excess;
	logic signed [EX_W-1:0]   man_diff;
	logic signed [MAN_W-1:0]  man_scaled;
	logic signed [MAN_W-1:0]  man_cmd;
	logic [DATA_WIDTH:0]      abs_err;
	logic [LIM_W-1:0]         lim_next;
	data_t                    lim_pos;
	data_t                    lim_neg;
	logic signed [DATA_WIDTH:0] verr_diff;
	logic signed [VERR_W-1:0] verr_next;
	data_t                    drive_next;
	logic                     accept;
	logic                     load_out;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		if (thr_q > THR_HIGH) begin
			excess = signed'({1'b0, thr_q}) - signed'({1'b0, THR_HIGH});
		end else if (thr_q < THR_LOW) begin
			excess = signed'({1'b0, thr_q}) - signed'({1'b0, THR_LOW});
		end else begin
			excess = '0;
		end
	end

	assign man_diff   = signed'({1'b0, thr_q}) - THR_MID;
	assign man_scaled = {man_diff, 7'b0};

	always_comb begin
		if (man_scaled > MAN_LIMIT) begin
			man_cmd = MAN_LIMIT;
		end else if (man_scaled < -MAN_LIMIT) begin
			man_cmd = -MAN_LIMIT;
		end else begin
			man_cmd = man_scaled;
		end
	end

	always_comb begin
		abs_err = err_q[DATA_WIDTH-1] ? (DATA_WIDTH+1)'(-signed'({err_q[DATA_WIDTH-1], err_q}))
			: {1'b0, err_q};
		if (abs_err < INT_LIM_MIN) begin
			lim_next = INT_LIM_MIN[LIM_W-1:0];
		end else if (abs_err > INT_LIM_MAX) begin
			lim_next = INT_LIM_MAX[LIM_W-1:0];
		end else begin
			lim_next = abs_err[LIM_W-1:0];
		end
	end

	assign lim_pos = signed'({{(DATA_WIDTH-LIM_W){1'b0}}, lim_q});
	assign lim_neg = -lim_pos;

	assign verr_diff = signed'({cmd_q[DATA_WIDTH-1], cmd_q})
		- signed'({{(DATA_WIDTH+1-VEL_W){vel_q[VEL_W-1]}}, vel_q});

	always_comb begin
		if (verr_diff > VERR_LIMIT) begin
			verr_next = VERR_MAX;
		end else if (verr_diff < -VERR_LIMIT) begin
			verr_next = -VERR_MAX;
		end else begin
			verr_next = verr_diff[VERR_W-1:0];
		end
	end

	assign drive_next = sat_wide(WIDE_W'(prod_q >>> 8));

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_ADJ: begin
				mul_en = 1'b1;
				mul_a  = {{(DATA_WIDTH-EX_W){excess[EX_W-1]}}, excess};
				mul_b  = dt_q;
			end
			ST_MI: begin
				mul_en = 1'b1;
				mul_a  = err_q;
				mul_b  = int_gain_q;
			end
			ST_MDT: begin
				mul_en = 1'b1;
				mul_a  = p_q;
				mul_b  = dt_q;
			end
			ST_CLP: begin
				mul_en = 1'b1;
				mul_a  = err_q;
				mul_b  = pos_gain_q;
			end
			ST_VMUL: begin
				mul_en = 1'b1;
				mul_a  = {{(DATA_WIDTH-VERR_W){verr_q[VERR_W-1]}}, verr_q};
				mul_b  = vel_gain_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	cahc_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain_q <= 16'd256;
			int_gain_q <= 16'd0;
			vel_gain_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POSITION_GAIN: pos_gain_q <= cfg_data;
				REG_INTEGRAL_GAIN: int_gain_q <= cfg_data;
				REG_VELOCITY_GAIN: vel_gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_mode_q <= MODE_MANUAL;
			tgt_q       <= '0;
			integ_q     <= '0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_mode_q <= mode_switch;
						if (mode_switch == MODE_HOLD && prev_mode_q != MODE_HOLD) begin
							tgt_q <= altitude;
						end
						if (mode_switch == MODE_HOLD) begin
							state_q <= ST_ADJ;
						end else if (mode_switch inside {MODE_MANUAL, MODE_MANUAL_ALT}) begin
							state_q <= ST_MAN;
						end else begin
							state_q <= ST_VERR;
						end
					end
				end
				ST_ADJ:  state_q <= ST_TGT;
				ST_TGT: begin
					tgt_q   <= sat_wide(WIDE_W'(tgt_q) + WIDE_W'(prod_q >>> 10));
					state_q <= ST_ERR;
				end
				ST_ERR:  state_q <= ST_MI;
				ST_MI:   state_q <= ST_PI;
				ST_PI:   state_q <= ST_MDT;
				ST_MDT:  state_q <= ST_INT;
				ST_INT: begin
					integ_q <= sat_wide(WIDE_W'(integ_q) + WIDE_W'(prod_q >>> 16));
					state_q <= ST_CLP;
				end
				ST_CLP: begin
					if (integ_q > lim_pos) begin
						integ_q <= lim_pos;
					end else if (integ_q < lim_neg) begin
						integ_q <= lim_neg;
					end
					state_q <= ST_PP;
				end
				ST_PP:   state_q <= ST_CMD;
				ST_CMD: begin
					cmd_q   <= sat_wide(WIDE_W'(p_q) + WIDE_W'(integ_q));
					state_q <= ST_VERR;
				end
				ST_MAN: begin
					integ_q <= '0;
					cmd_q   <= {{(DATA_WIDTH-MAN_W){man_cmd[MAN_W-1]}}, man_cmd};
					state_q <= ST_VERR;
				end
				ST_VERR: state_q <= ST_VMUL;
				ST_VMUL: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			thr_q <= throttle;
			alt_q <= altitude;
			vel_q <= vertical_velocity;
			dt_q  <= time_step;
		end
		if (state_q == ST_ERR) begin
			err_q <= sat_wide(WIDE_W'(tgt_q) - WIDE_W'(alt_q));
		end
		if (state_q == ST_PI || state_q == ST_PP) begin
			p_q <= sat_wide(WIDE_W'(prod_q >>> 8));
		end
		if (state_q == ST_INT) begin
			lim_q <= lim_next;
		end
		if (state_q == ST_VERR) begin
			verr_q <= verr_next;
		end
		if (load_out) begin
			out_tgt_q   <= tgt_q;
			out_cmd_q   <= cmd_q;
			out_drive_q <= drive_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign target_altitude = out_tgt_q;
	assign climb_command   = out_cmd_q;
	assign velocity_drive  = out_drive_q;

`ifndef SYNTHESIS
	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (integ_q <= 32'sd12800 && integ_q >= -32'sd12800))
		else $error("Integrator left its clamp range between ticks.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("Sequencer stayed idle after taking a word.");

	a_verr_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VMUL |-> (verr_q <= VERR_MAX && verr_q >= -VERR_MAX))
		else $error("Velocity error escaped its clamp.");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> state_q == ST_DONE)
		else $error("Result left the sequencer while the output register was full.");
`endif

endmodule

/* hdl/cahc_mul.sv */
// Shared signed-by-unsigned multiplier with a registered product.
module cahc_mul (
	input  logic                         clk,
	input  logic                         en,
	input  cahc_pkg::data_t              a,
	input  logic [cahc_pkg::GAIN_W-1:0]  b,
	output cahc_pkg::prod_t              prod_q
);
	import cahc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(signed'({1'b0, b}));
		end
	end

endmodule

/* verif/cascaded_altitude_hold_controller_top_test.sv */
// Self-checking testbench for the cascaded altitude hold controller top level.
`timescale 1ns / 100ps

module cascaded_altitude_hold_controller_top_test;
	import cahc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_MANUAL     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_KEEP       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MANUAL_ALT = 3'd3;

	localparam logic [IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_VELOCITY_GAIN = 2'd2;

	localparam int  SETTLE_CYCLES  = 20;
	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  PHASES         = 8;
	localparam int  PHASE_WORDS    = 100;
	localparam longint DATA_MAX    = 64'sd2147483647;
	localparam longint DATA_MIN    = -64'sd2147483648;

	typedef struct packed {
		data_t target;
		data_t climb;
		data_t drive;
	} tick_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [MODE_W-1:0]       mode_switch = '0;
	logic [THR_W-1:0]        throttle = '0;
	logic signed [31:0]      altitude = '0;
	logic signed [VEL_W-1:0] vertical_velocity = '0;
	logic [DT_W-1:0]         time_step = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [31:0]      target_altitude;
	logic signed [31:0]      climb_command;
	logic signed [31:0]      velocity_drive;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [GAIN_W-1:0]       cfg_data = '0;

	cascaded_altitude_hold_controller_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode_switch       (mode_switch),
		.throttle          (throttle),
		.altitude          (altitude),
		.vertical_velocity (vertical_velocity),
		.time_step         (time_step),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.target_altitude   (target_altitude),
		.climb_command     (climb_command),
		.velocity_drive    (velocity_drive),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	longint kp_gain = 256;
	longint ki_gain = 0;
	longint kv_gain = 256;
	logic [MODE_W-1:0] last_mode = '0;
	longint hold_target = 0;
	longint pos_integral = 0;
	longint climb_hold = 0;

	tick_result_t pending_ticks[$];
	int burst_left = 0;
	int words_sent = 0;
	int words_checked = 0;
	int hold_words = 0;
	int manual_words = 0;
	int keep_words = 0;
	int gain_settings = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic [31:0] ready_pattern = '1;
	int ready_left = 0;

	function automatic longint sat_data(input longint x);
		if (x > DATA_MAX) begin
			return DATA_MAX;
		end
		if (x < DATA_MIN) begin
			return DATA_MIN;
		end
		return x;
	endfunction

	function automatic longint limit_to(input longint x, input longint lo, input longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	function automatic tick_result_t compute_tick(input logic [MODE_W-1:0] m,
			input logic [THR_W-1:0] t_in, input data_t a_in,
			input logic signed [VEL_W-1:0] v_in, input logic [DT_W-1:0] d_in);
		tick_result_t r;
		longint t, a, v, d, err, p, lim, verr;
		t = longint'(t_in);
		a = longint'(a_in);
		v = longint'(v_in);
		d = longint'(d_in);
		if (m != last_mode && m == MODE_HOLD) begin
			hold_target = a;
		end
		if (m == MODE_HOLD) begin
			if (t > 600) begin
				hold_target = sat_data(hold_target + (((t - 600) * d) >>> 10));
			end
			if (t < 400) begin
				hold_target = sat_data(hold_target + (((t - 400) * d) >>> 10));
			end
			err = sat_data(hold_target - a);
			p = sat_data((err * ki_gain) >>> 8);
			pos_integral = sat_data(pos_integral + ((p * d) >>> 16));
			lim = limit_to((err < 0) ? -err : err, 20 * 256, 50 * 256);
			pos_integral = limit_to(pos_integral, -lim, lim);
			p = sat_data((err * kp_gain) >>> 8);
			climb_hold = sat_data(p + pos_integral);
		end
		if (m == MODE_MANUAL || m == MODE_MANUAL_ALT) begin
			pos_integral = 0;
			climb_hold = limit_to((t - 450) * 128, -250 * 256, 250 * 256);
		end
		last_mode = m;
		verr = limit_to(climb_hold - v, -150 * 256, 150 * 256);
		r.target = hold_target[31:0];
		r.climb = climb_hold[31:0];
		r.drive = data_t'(sat_data((verr * kv_gain) >>> 8));
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_word(input logic [MODE_W-1:0] m, input logic [THR_W-1:0] t,
			input data_t a, input logic signed [VEL_W-1:0] v, input logic [DT_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		mode_switch <= m;
		throttle <= t;
		altitude <= a;
		vertical_velocity <= v;
		time_step <= d;
		do @(posedge clk); while (!in_ready);
		pending_ticks.push_back(compute_tick(m, t, a, v, d));
		burst_left--;
		words_sent++;
		if (m == MODE_HOLD) begin
			hold_words++;
		end else if (m == MODE_MANUAL || m == MODE_MANUAL_ALT) begin
			manual_words++;
		end else begin
			keep_words++;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POSITION_GAIN: kp_gain = longint'(value);
			REG_INTEGRAL_GAIN: ki_gain = longint'(value);
			REG_VELOCITY_GAIN: kv_gain = longint'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
			input logic [GAIN_W-1:0] kv);
		write_gain(REG_POSITION_GAIN, kp);
		write_gain(REG_INTEGRAL_GAIN, ki);
		write_gain(REG_VELOCITY_GAIN, kv);
		gain_settings++;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 16'd256;
			default: return GAIN_W'($urandom_range(0, 1024));
		endcase
	endfunction

	// The first hold word after reset must latch the measured altitude.
	task automatic test_hold_after_reset();
		send_word(MODE_HOLD, 10'd500, 32'sd3160320, 24'sd0, 16'd65);
		send_word(MODE_HOLD, 10'd700, 32'sd3160320, 24'sd2560, 16'd6554);
		send_word(MODE_HOLD, 10'd300, 32'sd3158000, -24'sd2560, 16'd6554);
		wait_idle();
	endtask

	task automatic test_mode_sweep();
		int i;
		logic [THR_W-1:0] t;
		for (i = 0; i < 8; i++) begin
			case (i)
				0: t = 10'd0;
				1: t = 10'd399;
				2: t = 10'd400;
				3: t = 10'd450;
				4: t = 10'd600;
				5: t = 10'd601;
				6: t = 10'd1000;
				default: t = 10'd1023;
			endcase
			send_word(i[MODE_W-1:0], t, i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000,
				i[1] ? 24'sh7F_FFFF : 24'sh80_0000, i[0] ? 16'hFFFF : 16'h0000);
		end
		wait_idle();
	endtask

	// Saturation of products and sums at extreme gains, and the integrator clamp at both limits.
	task automatic test_gain_extremes();
		set_gains('1, '1, '1);
		send_word(MODE_MANUAL, 10'd1023, 32'sd0, 24'sh80_0000, 16'hFFFF);
		send_word(MODE_HOLD, 10'd1023, 32'sh7FFF_FF00, 24'sd0, 16'hFFFF);
		send_word(MODE_HOLD, 10'd0, 32'sh8000_0000, 24'sh7F_FFFF, 16'hFFFF);
		send_word(MODE_KEEP, 10'd0, 32'sd0, 24'sd0, 16'd0);
		send_word(MODE_MANUAL_ALT, 10'd450, 32'sd0, 24'sd0, 16'd0);
		send_word(MODE_HOLD, 10'd500, 32'sd0, 24'sd0, 16'hFFFF);
		send_word(MODE_HOLD, 10'd500, 32'sd2560, 24'sd0, 16'hFFFF);
		send_word(MODE_HOLD, 10'd500, -32'sd15360, 24'sd0, 16'hFFFF);
		wait_idle();
		set_gains('0, '0, '0);
		send_word(MODE_HOLD, 10'd601, 32'sd512, 24'sd100, 16'd1000);
		send_word(MODE_KEEP, 10'd800, 32'sd0, 24'sd0, 16'd1000);
		send_word(MODE_MANUAL, 10'd0, 32'sd0, 24'sd0, 16'd1000);
		wait_idle();
	endtask

	task automatic fly_hold_run(input int len);
		data_t alt;
		logic [MODE_W-1:0] m;
		logic [THR_W-1:0] thr;
		logic signed [VEL_W-1:0] vel;
		logic [DT_W-1:0] dt;
		int step;
		case ($urandom_range(0, 3))
			0: alt = $urandom;
			1: alt = 32'sh7FFF_0000;
			2: alt = 32'sh8000_FFFF;
			default: alt = int'($urandom_range(0, 51200000)) - 25600000;
		endcase
		if ($urandom_range(0, 1) == 0) begin
			send_word($urandom_range(0, 1) ? MODE_MANUAL : MODE_MANUAL_ALT,
				THR_W'($urandom), alt, VEL_W'($urandom), DT_W'($urandom));
		end
		for (step = 0; step < len; step++) begin
			alt = alt + (int'($urandom_range(0, 8192)) - 4096);
			thr = THR_W'(($urandom_range(0, 9) < 7) ? $urandom_range(400, 600)
				: $urandom_range(0, 1023));
			dt = DT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 1000) : $urandom);
			vel = VEL_W'(($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 76800)) - 38400
				: $urandom);
			m = MODE_HOLD;
			if ($urandom_range(0, 14) == 0) begin
				do m = MODE_W'($urandom_range(0, 7)); while (m == MODE_HOLD);
			end
			send_word(m, thr, alt, vel, dt);
		end
	endtask

	task automatic test_random_flight();
		int phase;
		int goal;
		int n;
		int k;
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				set_gains(pick_gain(), pick_gain(), pick_gain());
			end
			goal = words_sent + PHASE_WORDS;
			while (words_sent < goal) begin
				k = $urandom_range(0, 9);
				if (k < 7) begin
					fly_hold_run($urandom_range(4, 30));
				end else if (k < 8) begin
					for (n = $urandom_range(2, 8); n > 0; n--) begin
						send_word($urandom_range(0, 1) ? MODE_MANUAL : MODE_MANUAL_ALT,
							THR_W'($urandom), $urandom, VEL_W'($urandom), DT_W'($urandom));
					end
				end else begin
					for (n = $urandom_range(1, 6); n > 0; n--) begin
						send_word(MODE_W'($urandom), THR_W'($urandom), $urandom,
							VEL_W'($urandom), DT_W'($urandom));
					end
				end
			end
			wait_idle();
		end
	endtask

	always @(posedge clk) begin
		if (ready_left == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = $urandom;
				2: ready_pattern = 32'h0000_0001;
				default: ready_pattern = 32'h3333_3333;
			endcase
			ready_left = $urandom_range(32, 160);
		end
		out_ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
		ready_left--;
	end

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_ticks.size() == 0) begin
				report_error($sformatf("unexpected word target=%0d climb=%0d drive=%0d",
					target_altitude, climb_command, velocity_drive));
			end else begin
				want = pending_ticks.pop_front();
				if (target_altitude !== want.target) begin
					report_error($sformatf("word %0d target_altitude got %0d want %0d",
						words_checked, target_altitude, want.target));
				end
				if (climb_command !== want.climb) begin
					report_error($sformatf("word %0d climb_command got %0d want %0d",
						words_checked, climb_command, want.climb));
				end
				if (velocity_drive !== want.drive) begin
					report_error($sformatf("word %0d velocity_drive got %0d want %0d",
						words_checked, velocity_drive, want.drive));
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no handshake for %0d cycles, %0d words outstanding",
					$realtime, quiet_cycles, pending_ticks.size());
				$display("cascaded_altitude_hold_controller_top_test: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_hold_after_reset();
		test_mode_sweep();
		test_gain_extremes();
		test_random_flight();
		wait_idle();
		if (pending_ticks.size() != 0) begin
			report_error($sformatf("%0d words never arrived", pending_ticks.size()));
		end
		$display("Checked %0d output words over %0d gain settings.", words_checked,
			gain_settings + 1);
		$display("Ticks sent: %0d hold, %0d manual, %0d keep-mode; %0d mismatches.",
			hold_words, manual_words, keep_words, mismatches);
		if (mismatches == 0) begin
			$display("cascaded_altitude_hold_controller_top_test: clean");
		end else begin
			$display("cascaded_altitude_hold_controller_top_test: errors");
		end
		$finish;
	end

endmodule
